// ===== src/tofm_pkg.sv =====
`timescale 1ns / 1ps
package tofm_pkg;

  localparam int unsigned MASTER_CLOCK = 3579545;
  localparam int unsigned CLOCK_DIVIDE = 72;
  localparam int unsigned CORE_RATE    = MASTER_CLOCK / CLOCK_DIVIDE;
  localparam logic [15:0] CORE_RATE16  = 16'(CORE_RATE);

  localparam int unsigned MAX_OPS   = 18;
  localparam int unsigned DVD_W     = 38;
  localparam int unsigned DVS_W     = 18;
  localparam logic [8:0]  LEVEL_MAX = 9'd511;

  // register map
  localparam logic [7:0] REG_WSE    = 8'h01;
  localparam logic [2:0] GRP_OP_CHR = 3'b001;
  localparam logic [2:0] GRP_OP_TL  = 3'b010;
  localparam logic [2:0] GRP_OP_AD  = 3'b011;
  localparam logic [2:0] GRP_OP_SR  = 3'b100;
  localparam logic [2:0] GRP_OP_WS  = 3'b111;
  localparam logic [3:0] GRP_CH_FL  = 4'hA;
  localparam logic [3:0] GRP_CH_KEY = 4'hB;
  localparam logic [3:0] GRP_CH_FB  = 4'hC;

  typedef enum logic [2:0] {
    EP_OFF     = 3'd0,
    EP_ATTACK  = 3'd1,
    EP_DECAY   = 3'd2,
    EP_SUSTAIN = 3'd3,
    EP_RELEASE = 3'd4
  } env_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ENV,
    ST_STEP,
    ST_MUL,
    ST_DIV,
    ST_PACC,
    ST_OUT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic       egt;
    logic       ksr;
    logic [3:0] mult;
    logic [5:0] tl;
    logic [3:0] ar;
    logic [3:0] dr;
    logic [3:0] sl;
    logic [3:0] rr;
    logic [1:0] ws;
  } op_set_t;

  typedef struct packed {
    logic [9:0] fnum;
    logic [2:0] block;
    logic       key;
    logic [2:0] fb;
    logic       alg;
  } ch_set_t;

  typedef struct packed {
    env_phase_t ph;
    logic [8:0] lv;
  } env_t;

  typedef logic [11:0] lsin_tbl_t [256];

  function automatic lsin_tbl_t build_log_sin();
    lsin_tbl_t t;
    int x;
    int v;
    int bits;
    int tt;
    int frac;
    int lv;
    for (x = 0; x < 256; x++) begin
      v = x * (256 - x);
      if (v > 16383) v = 16383;
      if (v <= 1) begin
        t[x] = 12'd4095;
      end else begin
        bits = 0;
        tt = v;
        while (tt > 1) begin
          tt = tt >> 1;
          bits++;
        end
        frac = ((v << (14 - bits)) & 16383) >> 6;
        lv = ((14 - bits) << 8) - frac;
        if (lv > 4095) lv = 4095;
        t[x] = 12'(lv);
      end
    end
    return t;
  endfunction

  localparam lsin_tbl_t LOG_SIN_TBL = build_log_sin();

  function automatic logic [4:0] mult_x2(logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd0:    r = 5'd1;
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd4;
      4'd3:    r = 5'd6;
      4'd4:    r = 5'd8;
      4'd5:    r = 5'd10;
      4'd6:    r = 5'd12;
      4'd7:    r = 5'd14;
      4'd8:    r = 5'd16;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd20;
      4'd12:   r = 5'd24;
      4'd13:   r = 5'd24;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] first_op(logic [3:0] ch);
    logic [4:0] r;
    case (ch)
      4'd0:    r = 5'd0;
      4'd1:    r = 5'd1;
      4'd2:    r = 5'd2;
      4'd3:    r = 5'd6;
      4'd4:    r = 5'd7;
      4'd5:    r = 5'd8;
      4'd6:    r = 5'd12;
      4'd7:    r = 5'd13;
      4'd8:    r = 5'd14;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] eff_rate(logic [3:0] base, logic ksr, logic [2:0] blk);
    logic [6:0] r;
    if (base == 4'd0) return 6'd0;
    r = {1'b0, base, 2'b00} + (ksr ? {3'b0, blk, 1'b0} : {5'b0, blk[2:1]});
    return (r > 7'd63) ? 6'd63 : r[5:0];
  endfunction

  function automatic logic [3:0] rate_shift(logic [5:0] ra);
    return (ra[5:2] >= 4'd13) ? 4'd0 : 4'd13 - ra[5:2];
  endfunction

  function automatic logic [10:0] rate_inc(logic [5:0] ra);
    logic [13:0] s;
    s = 14'd1 << rate_shift(ra);
    return s[13:3];
  endfunction

  function automatic env_t env_step(env_phase_t ph, logic [8:0] lv, op_set_t os,
                                    logic [2:0] blk);
    env_t        r;
    logic [5:0]  ra;
    logic [3:0]  sh;
    logic [13:0] stp;
    logic [21:0] prod;
    logic [12:0] inc;
    logic [11:0] sumv;
    logic [8:0]  tgt;
    r.ph = ph;
    r.lv = lv;
    case (ph)
      EP_ATTACK: begin
        ra = eff_rate(os.ar, os.ksr, blk);
        if (ra >= 6'd60) begin
          r.lv = 9'd0;
          r.ph = EP_DECAY;
        end else if (ra != 6'd0) begin
          sh  = rate_shift(ra);
          stp = 14'd1 << sh;
          if ({5'b0, lv} > stp) begin
            prod = 22'(lv) << sh;
            inc  = prod[21:9];
            if (inc == 13'd0) inc = 13'd1;
            r.lv = ({4'b0, lv} > inc) ? 9'({4'b0, lv} - inc) : 9'd0;
          end else begin
            r.lv = 9'd0;
          end
          if (r.lv == 9'd0) r.ph = EP_DECAY;
        end
      end
      EP_DECAY: begin
        tgt  = (os.sl == 4'd15) ? LEVEL_MAX : {os.sl, 5'b0};
        ra   = eff_rate(os.dr, os.ksr, blk);
        sumv = 12'(lv);
        if (ra != 6'd0) begin
          sumv = sumv + 12'(rate_inc(ra));
          if (sumv > 12'(LEVEL_MAX)) sumv = 12'(LEVEL_MAX);
        end
        if (sumv >= 12'(tgt)) begin
          r.lv = tgt;
          r.ph = os.egt ? EP_SUSTAIN : EP_RELEASE;
        end else begin
          r.lv = sumv[8:0];
        end
      end
      EP_SUSTAIN: begin
        if (!os.egt) r.ph = EP_RELEASE;
      end
      EP_RELEASE: begin
        ra   = eff_rate(os.rr, os.ksr, blk);
        sumv = 12'(lv) + ((ra != 6'd0) ? 12'(rate_inc(ra)) : 12'd1);
        if (sumv >= 12'(LEVEL_MAX)) begin
          r.lv = LEVEL_MAX;
          r.ph = EP_OFF;
        end else begin
          r.lv = sumv[8:0];
        end
      end
      default: begin
        r.lv = LEVEL_MAX;
        r.ph = EP_OFF;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/tofm_div.sv =====
`timescale 1ns / 1ps
module tofm_div
  import tofm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[DVD_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== src/tofm_opout.sv =====
`timescale 1ns / 1ps
module tofm_opout
  import tofm_pkg::*;
(
  input  logic [31:0]        phase,
  input  logic [1:0]         ws,
  input  logic [8:0]         lvl,
  input  logic [5:0]         tl,
  output logic signed [14:0] amp_out
);

  logic [9:0]  idx;
  logic [8:0]  li;
  logic [7:0]  ti;
  logic        mute;
  logic        neg;
  logic [11:0] la;
  logic [13:0] total;
  logic [8:0]  mant;
  logic [13:0] amp;

  always_comb begin
    idx  = phase[21:12];
    mute = 1'b0;
    neg  = 1'b0;
    li   = idx[8:0];
    case (ws)
      2'd1: mute = idx[9];
      2'd2: ;
      2'd3: begin
        mute = idx[8];
        li   = {1'b0, idx[7:0]};
      end
      default: neg = idx[9];
    endcase
    // second quarter mirrors the first
    ti    = li[8] ? ~li[7:0] : li[7:0];
    la    = LOG_SIN_TBL[ti];
    total = 14'(la) + {2'b0, lvl, 3'b0} + {3'b0, tl, 5'b0};
    mant  = 9'd256 - {1'b0, total[7:0]};
    amp   = {mant, 5'b0} >> total[11:8];
    if (mute || total[13:12] != 2'b00) begin
      amp_out = '0;
    end else begin
      amp_out = neg ? -$signed({1'b0, amp}) : $signed({1'b0, amp});
    end
  end

endmodule

// ===== src/two_operator_fm_synth.sv =====
`timescale 1ns / 1ps
// Nine-channel two-operator FM tone generator. Each input item is either a
// register write (req_type 0) or a sample tick (req_type 1). A write is taken
// while idle and gives no result. A tick walks the channels in order and skips
// silent ones; for a sounding channel both operators run through one envelope
// unit, one 22x16 multiplier, one radix-2 divider (one quotient bit per cycle,
// dividing by the sample rate register) and one log-sine/exponent output unit.
// in_stall is high while a tick is in work; a finished sample sits in the
// output register while writes keep flowing in. The sample rate register lies
// at byte address 0 of the APB-style port.
module two_operator_fm_synth
  import tofm_pkg::*;
#(
  parameter int NUM_CHANNELS  = 9,
  parameter int NUM_OPERATORS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_reg_addr,
  input  logic [7:0]         in_reg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHCW = $clog2(NUM_CHANNELS + 1);
  localparam int OPW  = (NUM_OPERATORS > 1) ? $clog2(NUM_OPERATORS) : 1;

  // configuration
  logic [17:0] sr_r;
  logic        cfg_wr;

  // state stores
  op_set_t            op_set_r [NUM_OPERATORS];
  op_set_t            op_set_nxt [NUM_OPERATORS];
  env_phase_t         eph_r [MAX_OPS];
  env_phase_t         eph_nxt [MAX_OPS];
  logic [8:0]         elv_r [MAX_OPS];
  logic [8:0]         elv_nxt [MAX_OPS];
  logic [31:0]        pacc_r [MAX_OPS];
  logic [31:0]        pacc_nxt [MAX_OPS];
  logic signed [14:0] fbh0_r [NUM_CHANNELS];
  logic signed [14:0] fbh0_nxt [NUM_CHANNELS];
  logic signed [14:0] fbh1_r [NUM_CHANNELS];
  logic signed [14:0] fbh1_nxt [NUM_CHANNELS];
  ch_set_t            ch_set_r [NUM_CHANNELS];
  ch_set_t            ch_set_nxt [NUM_CHANNELS];
  logic               wse_r, wse_nxt;

  // sequencer
  seq_state_t         state_r, state_nxt;
  logic [CHCW-1:0]    ch_r, ch_nxt;
  logic               sel_r, sel_nxt;
  logic [21:0]        step_r, step_nxt;
  logic signed [14:0] o1_r, o1_nxt;
  logic signed [19:0] sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_sample_r, out_sample_nxt;

  // shared units
  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVD_W-1:0]   quot;
  logic [31:0]        op_phase;
  logic signed [14:0] opo;

  // working signals
  logic               in_acc;
  logic               out_acc;
  logic [CHW-1:0]     cur_ch;
  logic [4:0]         m_op;
  logic [4:0]         cur_op;
  op_set_t            cur_os;
  ch_set_t            cs;
  env_t               env;
  logic [16:0]        fshift;
  logic signed [15:0] fbsum;
  logic signed [31:0] fbx;
  logic signed [31:0] o1x;
  logic [3:0]         fbsh;
  logic signed [18:0] half;
  logic [4:0]         w_off;
  logic [4:0]         w_op;
  logic [3:0]         w_ch;
  logic [4:0]         w_m;
  ch_set_t            w_cs;

  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid_r && !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // APB-style sample rate register; word 1 reads as zero
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {14'd0, sr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r <= 18'd44100;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      sr_r <= cfg_pwdata[17:0];
    end
  end

  // current channel and operator under the sequencer
  assign cur_ch = ch_r[CHW-1:0];
  assign cs     = ch_set_r[cur_ch];
  assign m_op   = first_op(4'(ch_r));
  assign cur_op = sel_r ? m_op + 5'd3 : m_op;
  assign cur_os = (cur_op < 5'(NUM_OPERATORS)) ? op_set_r[cur_op[OPW-1:0]] : '0;

  // feedback: mean of the last two modulator outputs, scaled up by the feedback level
  assign fbsum = 16'(fbh0_r[cur_ch]) + 16'(fbh1_r[cur_ch]);
  assign fbsh  = 4'd3 + {1'b0, cs.fb};
  assign fbx   = 32'(fbsum >>> 1);
  assign o1x   = 32'(o1_r);

  always_comb begin
    if (!sel_r) begin
      op_phase = pacc_r[cur_op] + ((cs.fb != 3'd0) ? 32'(fbx << fbsh) : 32'd0);
    end else begin
      op_phase = pacc_r[cur_op] + ((!cs.alg) ? 32'(o1x << 12) : 32'd0);
    end
  end

  tofm_opout u_opout (
    .phase   (op_phase),
    .ws      (wse_r ? cur_os.ws : 2'd0),
    .lvl     (elv_r[cur_op]),
    .tl      (cur_os.tl),
    .amp_out (opo)
  );

  // phase step = (fnum << block) * mult_x2(mult) * core rate / sample rate, halved
  assign fshift = 17'(cs.fnum) << cs.block;
  assign dvd    = {16'd0, step_r} * {22'd0, CORE_RATE16};
  assign dvs    = (sr_r == 18'd0) ? 18'd1 : sr_r;

  tofm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot)
  );

  assign half = 19'(sum_r >>> 1);

  always_comb begin
    op_set_nxt     = op_set_r;
    eph_nxt        = eph_r;
    elv_nxt        = elv_r;
    pacc_nxt       = pacc_r;
    fbh0_nxt       = fbh0_r;
    fbh1_nxt       = fbh1_r;
    ch_set_nxt     = ch_set_r;
    wse_nxt        = wse_r;
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    sel_nxt        = sel_r;
    step_nxt       = step_r;
    o1_nxt         = o1_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_acc;
    out_sample_nxt = out_sample_r;
    div_start      = 1'b0;
    env            = env_step(eph_r[cur_op], elv_r[cur_op], cur_os, cs.block);
    w_off          = in_reg_addr[4:0];
    w_op           = 5'({3'b0, w_off[4:3]} * 5'd6) + {2'b0, w_off[2:0]};
    w_ch           = in_reg_addr[3:0];
    w_m            = first_op(w_ch);
    w_cs           = ch_set_r[w_ch[CHW-1:0]];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_req_type) begin
          ch_nxt    = '0;
          sel_nxt   = 1'b0;
          sum_nxt   = '0;
          state_nxt = ST_CHECK;
        end else if (in_acc) begin
          // register write decode
          if (in_reg_addr == REG_WSE) begin
            wse_nxt = in_reg_data[5];
          end else begin
            case (in_reg_addr[7:5]) inside
              GRP_OP_CHR, GRP_OP_TL, GRP_OP_AD, GRP_OP_SR, GRP_OP_WS: begin
                if (w_off < 5'h16 && w_off[2:0] < 3'd6 && w_op < 5'(NUM_OPERATORS)) begin
                  case (in_reg_addr[7:5])
                    GRP_OP_CHR: begin
                      op_set_nxt[w_op[OPW-1:0]].egt  = in_reg_data[5];
                      op_set_nxt[w_op[OPW-1:0]].ksr  = in_reg_data[4];
                      op_set_nxt[w_op[OPW-1:0]].mult = in_reg_data[3:0];
                    end
                    GRP_OP_TL: op_set_nxt[w_op[OPW-1:0]].tl = in_reg_data[5:0];
                    GRP_OP_AD: begin
                      op_set_nxt[w_op[OPW-1:0]].ar = in_reg_data[7:4];
                      op_set_nxt[w_op[OPW-1:0]].dr = in_reg_data[3:0];
                    end
                    GRP_OP_SR: begin
                      op_set_nxt[w_op[OPW-1:0]].sl = in_reg_data[7:4];
                      op_set_nxt[w_op[OPW-1:0]].rr = in_reg_data[3:0];
                    end
                    default: op_set_nxt[w_op[OPW-1:0]].ws = in_reg_data[1:0];
                  endcase
                end
              end
              default: begin
                if (w_ch < 4'(NUM_CHANNELS)) begin
                  case (in_reg_addr[7:4])
                    GRP_CH_FL: ch_set_nxt[w_ch[CHW-1:0]].fnum[7:0] = in_reg_data;
                    GRP_CH_KEY: begin
                      ch_set_nxt[w_ch[CHW-1:0]].fnum[9:8] = in_reg_data[1:0];
                      ch_set_nxt[w_ch[CHW-1:0]].block     = in_reg_data[4:2];
                      ch_set_nxt[w_ch[CHW-1:0]].key       = in_reg_data[5];
                      if (!w_cs.key && in_reg_data[5]) begin
                        // key on: restart both operators
                        eph_nxt[w_m]          = EP_ATTACK;
                        eph_nxt[w_m + 5'd3]   = EP_ATTACK;
                        elv_nxt[w_m]          = LEVEL_MAX;
                        elv_nxt[w_m + 5'd3]   = LEVEL_MAX;
                        pacc_nxt[w_m]         = '0;
                        pacc_nxt[w_m + 5'd3]  = '0;
                        fbh0_nxt[w_ch[CHW-1:0]] = '0;
                        fbh1_nxt[w_ch[CHW-1:0]] = '0;
                      end else if (w_cs.key && !in_reg_data[5]) begin
                        if (eph_r[w_m] != EP_OFF) eph_nxt[w_m] = EP_RELEASE;
                        if (eph_r[w_m + 5'd3] != EP_OFF) eph_nxt[w_m + 5'd3] = EP_RELEASE;
                      end
                    end
                    GRP_CH_FB: begin
                      ch_set_nxt[w_ch[CHW-1:0]].fb  = in_reg_data[3:1];
                      ch_set_nxt[w_ch[CHW-1:0]].alg = in_reg_data[0];
                    end
                    default: ;
                  endcase
                end
              end
            endcase
          end
        end
      end
      ST_CHECK: begin
        if (ch_r == CHCW'(NUM_CHANNELS)) begin
          state_nxt = ST_DONE;
        end else if (eph_r[m_op] == EP_OFF && eph_r[m_op + 5'd3] == EP_OFF) begin
          ch_nxt = ch_r + CHCW'(1);
        end else begin
          state_nxt = ST_ENV;
        end
      end
      ST_ENV: begin
        eph_nxt[cur_op] = env.ph;
        elv_nxt[cur_op] = env.lv;
        sel_nxt         = !sel_r;
        if (sel_r) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        step_nxt  = 22'(fshift * 22'(mult_x2(cur_os.mult)));
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_PACC;
      end
      ST_PACC: begin
        pacc_nxt[cur_op] = pacc_r[cur_op] + quot[32:1];
        sel_nxt          = !sel_r;
        state_nxt        = sel_r ? ST_OUT : ST_STEP;
      end
      ST_OUT: begin
        if (!sel_r) begin
          o1_nxt           = opo;
          fbh0_nxt[cur_ch] = fbh1_r[cur_ch];
          fbh1_nxt[cur_ch] = opo;
          sel_nxt          = 1'b1;
        end else begin
          sum_nxt   = sum_r + 20'(opo) + (cs.alg ? 20'(o1_r) : 20'sd0);
          sel_nxt   = 1'b0;
          ch_nxt    = ch_r + CHCW'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (!out_valid_r || out_acc) begin
          out_valid_nxt = 1'b1;
          if (half > 19'sd32767) begin
            out_sample_nxt = 16'sh7FFF;
          end else if (half < -19'sd32768) begin
            out_sample_nxt = 16'sh8000;
          end else begin
            out_sample_nxt = half[15:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    o1_r         <= o1_nxt;
    sum_r        <= sum_nxt;
    out_sample_r <= out_sample_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      wse_r       <= 1'b0;
      for (int i = 0; i < NUM_OPERATORS; i++) op_set_r[i] <= '0;
      for (int i = 0; i < MAX_OPS; i++) begin
        eph_r[i]  <= EP_OFF;
        elv_r[i]  <= LEVEL_MAX;
        pacc_r[i] <= '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        fbh0_r[i]   <= '0;
        fbh1_r[i]   <= '0;
        ch_set_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      wse_r       <= wse_nxt;
      op_set_r    <= op_set_nxt;
      eph_r       <= eph_nxt;
      elv_r       <= elv_nxt;
      pacc_r      <= pacc_nxt;
      fbh0_r      <= fbh0_nxt;
      fbh1_r      <= fbh1_nxt;
      ch_set_r    <= ch_set_nxt;
    end
  end

  // a new sample appears only from the final sequencer step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("sample raised outside the final step");

  // divider completes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider done outside the wait step");

  // a channel always starts with its modulator
  a_check_sel: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> !sel_r)
    else $error("operator select left on carrier");

  // channel counter never runs past the channel count
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= CHCW'(NUM_CHANNELS))
    else $error("channel counter out of range");

endmodule
